FILE: rtl/core/sadr_pkg.sv
// shared types, constants and helper functions for the slot allocator
package sadr_pkg;

    localparam int SLOTS     = 1024;
    localparam int ROW_BITS  = 32;
    localparam int ROWS      = SLOTS / ROW_BITS;
    localparam int ROW_AW    = $clog2(ROWS);
    localparam int BIT_AW    = $clog2(ROW_BITS);
    localparam int CODE_W    = $clog2(SLOTS);
    localparam int TOP_W     = CODE_W + 1;
    localparam logic [TOP_W-1:0] CAP_RESET = TOP_W'(SLOTS);

    typedef enum logic [2:0] {
        ACT_ALLOC   = 3'd0,
        ACT_RELEASE = 3'd1,
        ACT_QUERY   = 3'd2,
        ACT_TOUCH   = 3'd3,
        ACT_FLUSH   = 3'd4,
        ACT_CLEAR   = 3'd5,
        ACT_RSVD6   = 3'd6,
        ACT_RSVD7   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_RANGE   = 2'd2,
        ST_NOALLOC = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EXE,
        S_TRD,
        S_TRIM
    } t_state;

    typedef struct packed {
        t_action           action;
        logic [CODE_W-1:0] slot_code;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic [CODE_W-1:0] granted_slot;
        logic              in_use;
        logic              range_valid;
        logic [CODE_W-1:0] range_first;
        logic [CODE_W-1:0] range_last;
        logic [TOP_W-1:0]  used_top;
    } t_result;

    // index of lowest set bit
    function automatic logic [BIT_AW-1:0] lsb_idx(input logic [ROW_BITS-1:0] w);
        logic [BIT_AW-1:0] r;
        r = '0;
        for (int i = ROW_BITS - 1; i >= 0; i--) begin
            if (w[i]) r = BIT_AW'(i);
        end
        return r;
    endfunction

    // index of lowest set bit, row-vector width
    function automatic logic [ROW_AW-1:0] row_idx(input logic [ROWS-1:0] w);
        logic [ROW_AW-1:0] r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--) begin
            if (w[i]) r = ROW_AW'(i);
        end
        return r;
    endfunction

    // run of ones from the top bit down
    function automatic logic [BIT_AW:0] lead_ones(input logic [ROW_BITS-1:0] w);
        logic [BIT_AW:0] n;
        n = (BIT_AW+1)'(ROW_BITS);
        for (int i = 0; i < ROW_BITS; i++) begin
            if (!w[i]) n = (BIT_AW+1)'(ROW_BITS - 1 - i);
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/sadr_ram.sv
// generic single-port-write ram with registered read
module sadr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/slot_allocator_dirty_range_core.sv
// slot allocator top level: free map in ram, watermark and dirty range
// sequence: start is accepted while idle; the map row is read in S_RD, the action runs
//   in S_EXE and done is registered; a release of the top slot (other than slot 0) first walks
//   free-map rows down through S_TRD and S_TRIM; busy holds off new items until done; no output stall
// reset: synchronous; watermark 0, empty dirty range, capacity 1024; rows
//   with no live free bits read as zero, so no clearing pass is needed
module slot_allocator_dirty_range_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  sadr_pkg::t_item             i_item,
    output logic                        o_done,
    output sadr_pkg::t_result           o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [sadr_pkg::TOP_W-1:0]  i_cfg_data
);
    import sadr_pkg::*;

    t_state              r_state, n_state;
    t_action             r_act;
    logic [CODE_W-1:0]   r_code;
    logic [ROW_AW-1:0]   r_row, n_row;
    logic                r_found;
    logic [TOP_W-1:0]    r_wm, n_wm;
    logic [TOP_W-1:0]    r_cap;
    logic [ROWS-1:0]     r_row_any, n_row_any;
    logic                r_dany, n_dany;
    logic [CODE_W-1:0]   r_dlo, n_dlo, r_dhi, n_dhi;
    t_result             r_res, n_res;
    logic                r_done, n_done;

    logic                ram_we, ram_re;
    logic [ROW_BITS-1:0] ram_wdata, ram_rdata, word;
    logic                accept;
    logic [TOP_W-1:0]    cap_eff, cap_max, wm_m1;
    logic [CODE_W-1:0]   code_m1;
    logic [BIT_AW-1:0]   bpos, tpos;
    logic                slot_free;
    logic [ROW_BITS-1:0] shl;
    logic [BIT_AW:0]     nlead, lowpos, kdrop;
    logic                all_free;
    logic                mark;
    logic [CODE_W-1:0]   mark_slot;

    sadr_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_row),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_row),
        .o_rdata (ram_rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_res;
    assign ram_re      = (r_state == S_RD) || (r_state == S_TRD);

    assign cap_max   = (r_cap < r_wm) ? r_wm : r_cap;
    assign cap_eff   = (cap_max > CAP_RESET) ? CAP_RESET : cap_max;
    assign word      = r_row_any[r_row] ? ram_rdata : '0;
    assign bpos      = lsb_idx(word);
    assign slot_free = word[r_code[BIT_AW-1:0]];
    assign wm_m1     = r_wm - TOP_W'(1);
    assign code_m1   = r_code - CODE_W'(1);
    assign tpos      = wm_m1[BIT_AW-1:0];
    assign shl       = word << (BIT_AW'(ROW_BITS - 1) - tpos);
    assign nlead     = lead_ones(shl);
    assign all_free  = (nlead > {1'b0, tpos});
    assign kdrop     = all_free ? ({1'b0, tpos} + (BIT_AW+1)'(1)) : nlead;
    assign lowpos    = ({1'b0, tpos} + (BIT_AW+1)'(1)) - kdrop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wm      <= '0;
            r_cap     <= CAP_RESET;
            r_row_any <= '0;
            r_dany    <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wm      <= n_wm;
            r_row_any <= n_row_any;
            r_dany    <= n_dany;
            r_done    <= n_done;
            if (i_cfg_valid && o_cfg_ready) r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_dlo <= n_dlo;
        r_dhi <= n_dhi;
        r_res <= n_res;
        if (accept) begin
            r_act   <= i_item.action;
            r_code  <= i_item.slot_code;
            r_found <= |r_row_any;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_row     = r_row;
        n_wm      = r_wm;
        n_row_any = r_row_any;
        n_dany    = r_dany;
        n_dlo     = r_dlo;
        n_dhi     = r_dhi;
        n_res     = r_res;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = word;
        mark      = 1'b0;
        mark_slot = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RD;
                    n_row   = (i_item.action == ACT_ALLOC) ? row_idx(r_row_any)
                                                          : i_item.slot_code[CODE_W-1:BIT_AW];
                end
            end
            S_RD: begin
                n_state = S_EXE;
            end
            S_EXE: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                n_res   = '0;
                case (r_act)
                    ACT_ALLOC: begin
                        if (r_found) begin
                            ram_we    = 1'b1;
                            ram_wdata = word & ~(ROW_BITS'(1) << bpos);
                            n_row_any[r_row] = |ram_wdata;
                            n_res.granted_slot = {r_row, bpos};
                            mark      = 1'b1;
                            mark_slot = {r_row, bpos};
                        end else if (r_wm >= cap_eff) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_res.granted_slot = r_wm[CODE_W-1:0];
                            mark      = 1'b1;
                            mark_slot = r_wm[CODE_W-1:0];
                            n_wm      = r_wm + TOP_W'(1);
                        end
                    end
                    ACT_RELEASE: begin
                        if ({1'b0, r_code} >= cap_eff) begin
                            n_res.status = ST_RANGE;
                        end else if ({1'b0, r_code} >= r_wm || slot_free) begin
                            n_res.status = ST_NOALLOC;
                        end else begin
                            mark      = 1'b1;
                            mark_slot = r_code;
                            if ({1'b0, r_code} + TOP_W'(1) == r_wm) begin
                                n_wm = {1'b0, r_code};
                                if (r_code != '0) begin
                                    n_state = S_TRD;
                                    n_done  = 1'b0;
                                    n_row   = code_m1[CODE_W-1:BIT_AW];
                                end
                            end else begin
                                ram_we    = 1'b1;
                                ram_wdata = word | (ROW_BITS'(1) << r_code[BIT_AW-1:0]);
                                n_row_any[r_row] = 1'b1;
                            end
                        end
                    end
                    ACT_QUERY: begin
                        if ({1'b0, r_code} >= cap_eff) n_res.status = ST_RANGE;
                        else n_res.in_use = ({1'b0, r_code} < r_wm) && !slot_free;
                    end
                    ACT_TOUCH: begin
                        mark = 1'b1;
                        if ({1'b0, r_code} >= cap_eff) begin
                            n_res.status = ST_RANGE;
                        end else begin
                            mark_slot = r_code;
                            if ({1'b0, r_code} >= r_wm || slot_free)
                                n_res.status = ST_NOALLOC;
                        end
                    end
                    ACT_FLUSH: begin
                        if (r_dany) begin
                            n_res.range_valid = 1'b1;
                            n_res.range_first = r_dlo;
                            n_res.range_last  = r_dhi;
                        end
                        n_dany = 1'b0;
                    end
                    ACT_CLEAR: begin
                        n_row_any = '0;
                        n_wm      = '0;
                        n_dany    = 1'b0;
                    end
                    default: begin
                    end
                endcase
                if (mark) begin
                    n_dany = 1'b1;
                    n_dlo  = (!r_dany || mark_slot < r_dlo) ? mark_slot : r_dlo;
                    n_dhi  = (!r_dany || mark_slot > r_dhi) ? mark_slot : r_dhi;
                end
                n_res.used_top = n_wm;
            end
            S_TRD: begin
                n_state = S_TRIM;
            end
            S_TRIM: begin
                ram_we    = 1'b1;
                ram_wdata = word & ~({ROW_BITS{1'b1}} << lowpos);
                n_row_any[r_row] = |ram_wdata;
                n_wm      = r_wm - TOP_W'(kdrop);
                if (all_free && r_row != '0) begin
                    n_state = S_TRD;
                    n_row   = r_row - ROW_AW'(1);
                end else begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_res   = '0;
                    n_res.used_top = n_wm;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
